// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the voice activity detector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define EVAD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication that must hold in the following cycle.
`define EVAD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/evad_pkg.sv -----
// Package of the energy based voice activity detector: field widths,
// register indexes, reset values and event codes. No dependencies.
package evad_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ENERGY_W  = 31;
  localparam int EVENT_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int THR_W     = 32;
  localparam int FRAME_W   = 10;
  localparam int MS_W      = 16;
  localparam int RUN_W     = 16;

  localparam int MAX_FRAME_SAMPLES_DEF = 1024;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VAD_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TMO_MS  = 3'd4;

  // Reset values of the registers.
  localparam logic [THR_W-1:0]   THRESH_RST      = 32'd1000000;
  localparam logic [FRAME_W-1:0] FRAME_MS_RST    = 10'd20;
  localparam logic [MS_W-1:0]    MIN_SPEECH_RST  = 16'd200;
  localparam logic [MS_W-1:0]    SILENCE_TMO_RST = 16'd1000;

  // Event codes of a frame result.
  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_START = 2'd1;
  localparam logic [EVENT_W-1:0] EV_END   = 2'd2;

  // Largest mean energy of a frame: the square of the most negative sample.
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 31'h4000_0000;

endpackage

// ----- rtl/evad_if.sv -----
// Handshake channels of the voice activity detector: sample input, frame
// result output and register write port. Depends on evad_pkg.
interface evad_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic signed [evad_pkg::SAMPLE_W-1:0] sample;
  logic                               last_of_frame;

  modport source (output valid, func, sample, last_of_frame, input ready);
  modport sink   (input valid, func, sample, last_of_frame, output ready);
endinterface

interface evad_out_if;
  logic                          valid;
  logic                          ready;
  logic [evad_pkg::ENERGY_W-1:0] energy;
  logic                          is_speech_frame;
  logic                          speech_active;
  logic [evad_pkg::EVENT_W-1:0]  event_res;

  modport source (output valid, energy, is_speech_frame, speech_active, event_res,
                  input ready);
  modport sink   (input valid, energy, is_speech_frame, speech_active, event_res,
                  output ready);
endinterface

interface evad_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [evad_pkg::CFG_IDX_W-1:0] index;
  logic [evad_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/energy_voice_activity_detector.sv -----
// Energy based voice activity detector, top level. Depends on evad_pkg and evad_if.
// A sample word that does not close a frame goes through latch, square and accumulate;
// restart and disabled words are handled in the idle state alone. A word that closes a
// frame then runs the shared one-bit-per-cycle divider twice (mean energy, frames needed)
// and waits for a free output register. New words are taken only while the block is idle.
// Reset: rst_ni is asynchronous; it restores the register reset values and clears all state.
module energy_voice_activity_detector #(
  parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  evad_cfg_if.sink   cfg_i,
  evad_in_if.sink    in_i,
  evad_out_if.source out_o
);

  // Widths that follow from the longest frame. The sum of squares is at most
  // MAX_FRAME_SAMPLES * 2^30, so it fits CNT_W + 30 bits.
  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int MAG_W = evad_pkg::SAMPLE_W;
  localparam int SQ_W  = 2 * MAG_W - 1;
  localparam int SUM_W = CNT_W + SQ_W - 1;
  // The shared divider handles both the energy division (sum by sample count)
  // and the ceiling division of a duration by the frame length.
  localparam int CEIL_W = evad_pkg::MS_W + 1;
  localparam int DIV_W  = (SUM_W > CEIL_W) ? SUM_W : CEIL_W;
  localparam int DVS_W  = (CNT_W > evad_pkg::FRAME_W) ? CNT_W : evad_pkg::FRAME_W;
  localparam int IT_W   = $clog2(DIV_W + 1);
  localparam int RUN_W  = evad_pkg::RUN_W;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME_SAMPLES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] ST_MUL  = 3'd1;  // square the magnitude
  localparam logic [2:0] ST_ACC  = 3'd2;  // accumulate, detect frame end
  localparam logic [2:0] ST_DIVE = 3'd3;  // divider: mean energy
  localparam logic [2:0] ST_SPC  = 3'd4;  // classify frame, update runs
  localparam logic [2:0] ST_DIVT = 3'd5;  // divider: frames needed
  localparam logic [2:0] ST_FIN  = 3'd6;  // decide event, load output register

  logic [2:0] state_q;

  // Configuration registers.
  logic                            vad_enable_q;
  logic [evad_pkg::THR_W-1:0]      thresh_q;
  logic [evad_pkg::FRAME_W-1:0]    frame_ms_q;
  logic [evad_pkg::MS_W-1:0]       min_speech_q;
  logic [evad_pkg::MS_W-1:0]       silence_tmo_q;

  // Detector state.
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RUN_W-1:0] speech_run_q;
  logic [RUN_W-1:0] silence_run_q;
  logic             in_speech_q;

  // Per-word and per-frame working registers.
  logic [MAG_W-1:0]              mag_q;
  logic                          last_q;
  logic [SQ_W-1:0]               sq_q;
  logic [evad_pkg::ENERGY_W-1:0] frm_energy_q;
  logic                          frm_speech_q;

  // Shared restoring divider.
  logic [DIV_W-1:0] quot_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [IT_W-1:0]  iter_q;

  // Output register.
  logic                          out_valid_q;
  logic [evad_pkg::ENERGY_W-1:0] out_energy_q;
  logic                          out_speech_q;
  logic                          out_active_q;
  logic [evad_pkg::EVENT_W-1:0]  out_event_q;

  // Magnitude of the incoming sample; the most negative value maps to 0x8000.
  logic [MAG_W-1:0] in_mag;
  assign in_mag = in_i.sample[MAG_W-1] ? (~in_i.sample + 1'b1) : in_i.sample;

  // One multiplier, registered before the accumulator.
  logic [2*MAG_W-1:0] sq_full;
  assign sq_full = mag_q * mag_q;

  logic [SUM_W-1:0] sum_d;
  logic [CNT_W-1:0] cnt_d;
  logic             frame_end;
  assign sum_d     = sum_q + SUM_W'(sq_q);
  assign cnt_d     = cnt_q + 1'b1;
  assign frame_end = last_q || (cnt_d == CNT_LAST);

  // One divider step: shift in the next dividend bit, subtract when possible.
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_dif;
  logic             rem_ge;
  logic [DVS_W-1:0] rem_d;
  logic [DIV_W-1:0] quot_d;
  assign rem_sh  = {rem_q, quot_q[DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_dif = rem_sh - {1'b0, dvs_q};
  assign rem_d   = rem_ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign quot_d  = {quot_q[DIV_W-2:0], rem_ge};

  // Frame classification from the finished energy quotient.
  logic is_speech;
  assign is_speech = {1'b0, quot_q[evad_pkg::ENERGY_W-1:0]} > thresh_q;

  // Ceiling division operand: duration plus frame length minus one, where a
  // frame length of zero counts as one.
  logic [evad_pkg::FRAME_W-1:0] frame_len;
  logic [evad_pkg::MS_W-1:0]    dur_ms;
  logic [CEIL_W-1:0]            ceil_dvd;
  assign frame_len = (frame_ms_q == '0) ? evad_pkg::FRAME_W'(1) : frame_ms_q;
  assign dur_ms    = is_speech ? min_speech_q : silence_tmo_q;
  assign ceil_dvd  = {1'b0, dur_ms} + CEIL_W'(frame_len) - CEIL_W'(1);

  // The required frame count is in the quotient once the second division ends.
  logic [RUN_W-1:0] run_now;
  logic             run_met;
  assign run_now = frm_speech_q ? speech_run_q : silence_run_q;
  assign run_met = DIV_W'(run_now) >= quot_q;

  // Speech starts on a long enough run of speech frames and ends on a long
  // enough run of silence frames.
  logic start_ev;
  logic end_ev;
  logic active_next;
  assign start_ev    = frm_speech_q && !in_speech_q && run_met;
  assign end_ev      = !frm_speech_q && in_speech_q && run_met;
  assign active_next = start_ev || (in_speech_q && !end_ev);

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  logic in_acc;
  logic cfg_acc;
  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid           = out_valid_q;
  assign out_o.energy          = out_energy_q;
  assign out_o.is_speech_frame = out_speech_q;
  assign out_o.speech_active   = out_active_q;
  assign out_o.event_res       = out_event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      vad_enable_q  <= 1'b0;
      thresh_q      <= evad_pkg::THRESH_RST;
      frame_ms_q    <= evad_pkg::FRAME_MS_RST;
      min_speech_q  <= evad_pkg::MIN_SPEECH_RST;
      silence_tmo_q <= evad_pkg::SILENCE_TMO_RST;
      sum_q         <= '0;
      cnt_q         <= '0;
      speech_run_q  <= '0;
      silence_run_q <= '0;
      in_speech_q   <= 1'b0;
      mag_q         <= '0;
      last_q        <= 1'b0;
      sq_q          <= '0;
      frm_energy_q  <= '0;
      frm_speech_q  <= 1'b0;
      quot_q        <= '0;
      rem_q         <= '0;
      dvs_q         <= '0;
      iter_q        <= '0;
      out_valid_q   <= 1'b0;
      out_energy_q  <= '0;
      out_speech_q  <= 1'b0;
      out_active_q  <= 1'b0;
      out_event_q   <= evad_pkg::EV_NONE;
    end else begin
      // A result word that leaves while the next one is loaded is replaced below.
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.func) begin
              // Restart clears the detector whatever the enable holds.
              sum_q         <= '0;
              cnt_q         <= '0;
              speech_run_q  <= '0;
              silence_run_q <= '0;
              in_speech_q   <= 1'b0;
            end else if (vad_enable_q) begin
              mag_q   <= in_mag;
              last_q  <= in_i.last_of_frame;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          sq_q    <= sq_full[SQ_W-1:0];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (frame_end) begin
            sum_q   <= '0;
            cnt_q   <= '0;
            quot_q  <= sum_d;
            rem_q   <= '0;
            dvs_q   <= DVS_W'(cnt_d);
            iter_q  <= IT_W'(DIV_W);
            state_q <= ST_DIVE;
          end else begin
            sum_q   <= sum_d;
            cnt_q   <= cnt_d;
            state_q <= ST_IDLE;
          end
        end
        ST_DIVE, ST_DIVT: begin
          quot_q <= quot_d;
          rem_q  <= rem_d;
          iter_q <= iter_q - 1'b1;
          if (iter_q == IT_W'(1)) begin
            state_q <= (state_q == ST_DIVE) ? ST_SPC : ST_FIN;
          end
        end
        ST_SPC: begin
          frm_energy_q <= quot_q[evad_pkg::ENERGY_W-1:0];
          frm_speech_q <= is_speech;
          // Consecutive frame counters saturate at their maximum.
          if (is_speech) begin
            silence_run_q <= '0;
            if (speech_run_q != evad_pkg::RUN_MAX) begin
              speech_run_q <= speech_run_q + 1'b1;
            end
          end else begin
            speech_run_q <= '0;
            if (silence_run_q != evad_pkg::RUN_MAX) begin
              silence_run_q <= silence_run_q + 1'b1;
            end
          end
          quot_q  <= DIV_W'(ceil_dvd);
          rem_q   <= '0;
          dvs_q   <= DVS_W'(frame_len);
          iter_q  <= IT_W'(DIV_W);
          state_q <= ST_DIVT;
        end
        ST_FIN: begin
          // Hold here until the previous result word has left.
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_energy_q <= frm_energy_q;
            out_speech_q <= frm_speech_q;
            out_active_q <= active_next;
            in_speech_q  <= active_next;
            if (start_ev) begin
              out_event_q <= evad_pkg::EV_START;
            end else if (end_ev) begin
              out_event_q <= evad_pkg::EV_END;
            end else begin
              out_event_q <= evad_pkg::EV_NONE;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // The user must write registers only while the block is idle; the block does not enforce
      // it. Turning detection on clears the accumulator, both runs and the speech state.
      if (cfg_acc) begin
        case (cfg_i.index)
          evad_pkg::REG_VAD_ENABLE: begin
            if (cfg_i.data[0] && !vad_enable_q) begin
              sum_q         <= '0;
              cnt_q         <= '0;
              speech_run_q  <= '0;
              silence_run_q <= '0;
              in_speech_q   <= 1'b0;
            end
            vad_enable_q <= cfg_i.data[0];
          end
          evad_pkg::REG_ENERGY_THRESH:  thresh_q      <= cfg_i.data;
          evad_pkg::REG_FRAME_MS:       frame_ms_q    <= cfg_i.data[evad_pkg::FRAME_W-1:0];
          evad_pkg::REG_MIN_SPEECH_MS:  min_speech_q  <= cfg_i.data[evad_pkg::MS_W-1:0];
          evad_pkg::REG_SILENCE_TMO_MS: silence_tmo_q <= cfg_i.data[evad_pkg::MS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/evad_checker.sv -----
// Port-level checker of the voice activity detector and its bind statement.
// Depends on evad_pkg, assert_macros.svh and energy_voice_activity_detector.
`include "assert_macros.svh"

module evad_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [evad_pkg::ENERGY_W-1:0] out_energy_i,
  input logic                          out_speech_i,
  input logic                          out_active_i,
  input logic [evad_pkg::EVENT_W-1:0]  out_event_i
);

  // A result word that is not taken stays offered.
  `EVAD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result word dropped while stalled")

  // Speech can only start on a speech frame, and the detector is then active.
  `EVAD_ASSERT_IMP(a_start, clk_i, rst_ni, out_valid_i && (out_event_i == evad_pkg::EV_START), out_speech_i && out_active_i, "speech start without speech frame or active state")

  // Speech can only end on a silence frame, and the detector is then inactive.
  `EVAD_ASSERT_IMP(a_end, clk_i, rst_ni, out_valid_i && (out_event_i == evad_pkg::EV_END), !out_speech_i && !out_active_i, "speech end without silence frame or inactive state")

  // The mean of squared 16-bit samples never exceeds the square of the most negative one.
  `EVAD_ASSERT_IMP(a_energy_max, clk_i, rst_ni, out_valid_i, out_energy_i <= evad_pkg::ENERGY_MAX, "frame energy out of range")

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_energy_i (out_o.energy),
  .out_speech_i (out_o.is_speech_frame),
  .out_active_i (out_o.speech_active),
  .out_event_i  (out_o.event_res)
);
